// ----- sv/madt_pkg.sv -----
// Shared constants, codes and the event type for the MADT cpu entry parser.
`timescale 1ns / 1ps

package madt_pkg;

    // Upper bound on recorded cpus
    localparam int MAX_CPUS = 16;

    // Fixed table layout
    localparam int TABLE_LEN_OFFSET   = 4;
    localparam int APIC_BASE_OFFSET   = 36;
    localparam int FIRST_ENTRY_OFFSET = 44;
    localparam int MIN_ENTRY_LEN      = 2;
    localparam int MIN_CPU_ENTRY_LEN  = 8;
    localparam int FIELD_BYTES        = 4;

    // Byte positions inside one entry
    localparam logic [31:0] REL_TYPE       = 32'd0;
    localparam logic [31:0] REL_LENGTH     = 32'd1;
    localparam logic [31:0] REL_PROC_ID    = 32'd2;
    localparam logic [31:0] REL_APIC_ID    = 32'd3;
    localparam logic [31:0] REL_FLAGS_LAST = 32'd7;

    // Entry type of a processor local APIC entry
    localparam logic [7:0] ENTRY_LOCAL_APIC = 8'd0;

    // Input word modes
    localparam logic [1:0] MODE_FIRST  = 2'd0;
    localparam logic [1:0] MODE_NEXT   = 2'd1;
    localparam logic [1:0] MODE_ABSENT = 2'd2;

    // Result kinds
    localparam logic KIND_CPU     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Event queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One event: what a single input word produces, one or two results
    typedef struct packed {
        logic        has_rec;
        logic        has_sum;
        logic [3:0]  cpu_index;
        logic [7:0]  acpi_proc_id;
        logic [7:0]  apic_id;
        logic [31:0] cpu_flags;
        logic        bootstrap;
        logic [31:0] apic_base_addr;
        logic [4:0]  rec_total;
        logic [4:0]  sum_total;
        logic        bad_length_stop;
    } madt_evt_t;

endpackage

// ----- sv/madt_if.sv -----
// Handshake channels: table byte input and cpu record and summary output.
`timescale 1ns / 1ps

interface madt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface madt_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [3:0]  cpu_index;
    logic [7:0]  acpi_proc_id;
    logic [7:0]  apic_id;
    logic [31:0] cpu_flags;
    logic        enabled;
    logic        bootstrap;
    logic [31:0] apic_base_addr;
    logic [4:0]  cpu_total;
    logic        bad_length_stop;
    logic        last;

    modport source (
        output valid, output kind, output cpu_index, output acpi_proc_id,
        output apic_id, output cpu_flags, output enabled, output bootstrap,
        output apic_base_addr, output cpu_total, output bad_length_stop,
        output last, input ready
    );
    modport sink (
        input valid, input kind, input cpu_index, input acpi_proc_id,
        input apic_id, input cpu_flags, input enabled, input bootstrap,
        input apic_base_addr, input cpu_total, input bad_length_stop,
        input last, output ready
    );
endinterface

// ----- sv/madt_front.sv -----
// Front end: takes table bytes, walks the entries and pushes result events.
`timescale 1ns / 1ps

module madt_front (
    input  logic                clk,
    input  logic                rst_n,
    madt_in_if.sink             table_bytes,
    input  logic                q_full,
    output logic                evt_push,
    output madt_pkg::madt_evt_t evt
);
    import madt_pkg::*;

    // Distance from the offset to the first entry start, right after a restart
    localparam logic [31:0] REL_AT_RESTART = 32'(-FIRST_ENTRY_OFFSET);

    logic        accept;
    logic [7:0]  b;

    logic [31:0] offset_reg, offset_next;
    logic [31:0] rel_reg, rel_next;
    logic [31:0] start_reg, start_next;
    logic [4:0]  cpus_reg, cpus_next;
    logic        finished_reg, finished_next;
    logic [31:0] tlen_reg, tlen_next;
    logic [31:0] base_reg, base_next;
    logic [7:0]  etype_reg, etype_next;
    logic [7:0]  elen_reg, elen_next;
    logic [7:0]  pid_reg, pid_next;
    logic [7:0]  aid_reg, aid_next;
    logic [31:0] flags_reg, flags_next;

    logic        advance;
    logic        restart;

    assign table_bytes.ready = !q_full;
    assign accept  = table_bytes.valid && table_bytes.ready;
    assign b       = table_bytes.data_byte;
    assign restart = (table_bytes.mode == MODE_FIRST);

    always_comb
    begin
        offset_next   = offset_reg;
        rel_next      = rel_reg;
        start_next    = start_reg;
        cpus_next     = cpus_reg;
        finished_next = finished_reg;
        tlen_next     = tlen_reg;
        base_next     = base_reg;
        etype_next    = etype_reg;
        elen_next     = elen_reg;
        pid_next      = pid_reg;
        aid_next      = aid_reg;
        flags_next    = flags_reg;
        advance       = 1'b0;
        evt_push      = 1'b0;
        evt           = '0;

        if (accept && table_bytes.mode == MODE_ABSENT)
        begin
            // No table: one fallback cpu and a summary
            offset_next   = '0;
            rel_next      = REL_AT_RESTART;
            start_next    = 32'(FIRST_ENTRY_OFFSET);
            cpus_next     = 5'd1;
            finished_next = 1'b1;
            tlen_next     = '0;
            base_next     = '0;
            etype_next    = '0;
            elen_next     = '0;
            pid_next      = '0;
            aid_next      = '0;
            flags_next    = '0;
            evt_push      = 1'b1;
            evt.has_rec   = 1'b1;
            evt.has_sum   = 1'b1;
            evt.cpu_flags = 32'd1;
            evt.bootstrap = 1'b1;
            evt.sum_total = 5'd1;
        end
        else if (accept && (restart ||
                 (table_bytes.mode == MODE_NEXT && !finished_reg)))
        begin
            if (restart)
            begin
                offset_next = '0;
                rel_next    = REL_AT_RESTART;
                start_next  = 32'(FIRST_ENTRY_OFFSET);
                cpus_next   = '0;
                tlen_next   = '0;
                base_next   = '0;
                etype_next  = '0;
                elen_next   = '0;
                pid_next    = '0;
                aid_next    = '0;
                flags_next  = '0;
            end
            finished_next = 1'b0;

            // Header fields, little-endian
            if (offset_next >= 32'(TABLE_LEN_OFFSET) &&
                offset_next < 32'(TABLE_LEN_OFFSET + FIELD_BYTES))
            begin
                for (int i = 0; i < FIELD_BYTES; i++)
                begin
                    if (offset_next[1:0] == 2'(i))
                        tlen_next[8*i +: 8] = tlen_next[8*i +: 8] | b;
                end
            end
            if (offset_next >= 32'(APIC_BASE_OFFSET) &&
                offset_next < 32'(APIC_BASE_OFFSET + FIELD_BYTES))
            begin
                for (int i = 0; i < FIELD_BYTES; i++)
                begin
                    if (offset_next[1:0] == 2'(i))
                        base_next[8*i +: 8] = base_next[8*i +: 8] | b;
                end
            end

            // Entry walk
            if (offset_next >= 32'(FIRST_ENTRY_OFFSET))
            begin
                if (rel_next == REL_TYPE)
                begin
                    etype_next = b;
                end
                else if (rel_next == REL_LENGTH)
                begin
                    elen_next = b;
                    if (b < 8'(MIN_ENTRY_LEN))
                    begin
                        finished_next       = 1'b1;
                        evt_push            = 1'b1;
                        evt.has_sum         = 1'b1;
                        evt.apic_base_addr  = base_next;
                        evt.sum_total       = cpus_next;
                        evt.bad_length_stop = 1'b1;
                    end
                end
                else if (rel_next == REL_PROC_ID)
                begin
                    pid_next = b;
                end
                else if (rel_next == REL_APIC_ID)
                begin
                    aid_next = b;
                end
                else if (rel_next <= REL_FLAGS_LAST)
                begin
                    for (int i = 0; i < FIELD_BYTES; i++)
                    begin
                        if (rel_next[1:0] == 2'(i))
                            flags_next[8*i +: 8] = b;
                    end
                    if (rel_next == REL_FLAGS_LAST && etype_next == ENTRY_LOCAL_APIC &&
                        elen_next >= 8'(MIN_CPU_ENTRY_LEN) &&
                        32'(cpus_next) < 32'(MAX_CPUS))
                    begin
                        evt_push           = 1'b1;
                        evt.has_rec        = 1'b1;
                        evt.cpu_index      = cpus_next[3:0];
                        evt.acpi_proc_id   = pid_next;
                        evt.apic_id        = aid_next;
                        evt.cpu_flags      = flags_next;
                        evt.bootstrap      = (cpus_next == '0);
                        evt.apic_base_addr = base_next;
                        evt.rec_total      = cpus_next + 5'd1;
                        cpus_next          = cpus_next + 5'd1;
                    end
                end
                if (!finished_next && rel_next != REL_TYPE &&
                    rel_next == {24'd0, elen_next} - 32'd1)
                begin
                    advance    = 1'b1;
                    start_next = start_next + {24'd0, elen_next};
                end
            end

            rel_next = advance ? '0 : rel_next + 32'd1;

            // End of table: next entry header would not fit
            if (!finished_next && rel_next == '0 &&
                ({1'b0, start_next} + 33'd2 > {1'b0, tlen_next}))
            begin
                finished_next      = 1'b1;
                evt_push           = 1'b1;
                evt.has_sum        = 1'b1;
                evt.apic_base_addr = base_next;
                evt.sum_total      = cpus_next;
            end

            offset_next = offset_next + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            rel_reg      <= REL_AT_RESTART;
            start_reg    <= 32'(FIRST_ENTRY_OFFSET);
            cpus_reg     <= '0;
            finished_reg <= 1'b1;
        end
        else
        begin
            offset_reg   <= offset_next;
            rel_reg      <= rel_next;
            start_reg    <= start_next;
            cpus_reg     <= cpus_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tlen_reg  <= tlen_next;
        base_reg  <= base_next;
        etype_reg <= etype_next;
        elen_reg  <= elen_next;
        pid_reg   <= pid_next;
        aid_reg   <= aid_next;
        flags_reg <= flags_next;
    end

endmodule

// ----- sv/madt_queue.sv -----
// Short event queue that decouples the front end from the result stage.
`timescale 1ns / 1ps

module madt_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  madt_pkg::madt_evt_t push_evt,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output madt_pkg::madt_evt_t head_evt
);
    import madt_pkg::*;

    madt_evt_t          slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_evt   = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + QPTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_evt;
    end

endmodule

// ----- sv/madt_back.sv -----
// Result stage: expands each event into one or two registered result words.
`timescale 1ns / 1ps

module madt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  madt_pkg::madt_evt_t head_evt,
    output logic                pop,
    madt_out_if.source          records
);
    import madt_pkg::*;

    logic        valid_reg, valid_next;
    logic        sum_phase_reg, sum_phase_next;
    logic        load;
    logic        emit_rec;

    logic        kind_reg, kind_next;
    logic [3:0]  index_reg, index_next;
    logic [7:0]  pid_reg, pid_next;
    logic [7:0]  aid_reg, aid_next;
    logic [31:0] flags_reg, flags_next;
    logic        boot_reg, boot_next;
    logic [31:0] base_reg, base_next;
    logic [4:0]  total_reg, total_next;
    logic        bad_reg, bad_next;
    logic        last_reg, last_next;

    assign load     = head_valid && (!valid_reg || records.ready);
    assign emit_rec = head_evt.has_rec && !sum_phase_reg;

    always_comb
    begin
        valid_next     = valid_reg;
        sum_phase_next = sum_phase_reg;
        pop            = 1'b0;
        kind_next      = kind_reg;
        index_next     = index_reg;
        pid_next       = pid_reg;
        aid_next       = aid_reg;
        flags_next     = flags_reg;
        boot_next      = boot_reg;
        base_next      = base_reg;
        total_next     = total_reg;
        bad_next       = bad_reg;
        last_next      = last_reg;

        if (records.ready)
            valid_next = 1'b0;

        if (load)
        begin
            valid_next = 1'b1;
            base_next  = head_evt.apic_base_addr;
            if (emit_rec)
            begin
                kind_next  = KIND_CPU;
                index_next = head_evt.cpu_index;
                pid_next   = head_evt.acpi_proc_id;
                aid_next   = head_evt.apic_id;
                flags_next = head_evt.cpu_flags;
                boot_next  = head_evt.bootstrap;
                total_next = head_evt.rec_total;
                bad_next   = 1'b0;
                last_next  = !head_evt.has_sum;
                if (head_evt.has_sum)
                    sum_phase_next = 1'b1;
                else
                    pop = 1'b1;
            end
            else
            begin
                kind_next      = KIND_SUMMARY;
                index_next     = '0;
                pid_next       = '0;
                aid_next       = '0;
                flags_next     = '0;
                boot_next      = 1'b0;
                total_next     = head_evt.sum_total;
                bad_next       = head_evt.bad_length_stop;
                last_next      = 1'b1;
                sum_phase_next = 1'b0;
                pop            = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            sum_phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            sum_phase_reg <= sum_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        index_reg <= index_next;
        pid_reg   <= pid_next;
        aid_reg   <= aid_next;
        flags_reg <= flags_next;
        boot_reg  <= boot_next;
        base_reg  <= base_next;
        total_reg <= total_next;
        bad_reg   <= bad_next;
        last_reg  <= last_next;
    end

    assign records.valid           = valid_reg;
    assign records.kind            = kind_reg;
    assign records.cpu_index       = index_reg;
    assign records.acpi_proc_id    = pid_reg;
    assign records.apic_id         = aid_reg;
    assign records.cpu_flags       = flags_reg;
    assign records.enabled         = flags_reg[0];
    assign records.bootstrap       = boot_reg;
    assign records.apic_base_addr  = base_reg;
    assign records.cpu_total       = total_reg;
    assign records.bad_length_stop = bad_reg;
    assign records.last            = last_reg;

endmodule

// ----- sv/acpi_madt_cpu_entry_parser.sv -----
// Top level of the MADT local APIC entry parser: front end, event queue, result stage.
`timescale 1ns / 1ps

// Channel       Dir  Word                       Accepted when
// ------------  ---  -------------------------  -------------------------
// table_bytes   in   mode, data_byte            valid && ready
// records       out  cpu record or summary      valid && ready
//
// One table byte is taken every cycle while the event queue has room; the
// byte walk, header capture and entry decode are combinational. The result
// stage sends one word per cycle while records is ready, so a byte that
// yields a cpu record plus a summary (or a table-absent word) gives two
// output words. A word is registered in the event queue, then in the result
// stage. Reset leaves the parser finished: next-byte words are dropped until
// a first-byte word restarts the walk. Output stalls fill the queue and then
// drop ready on the input side; input gaps never stall the output.

module acpi_madt_cpu_entry_parser (
    input  logic       clk,
    input  logic       rst_n,
    madt_in_if.sink    table_bytes,
    madt_out_if.source records
);
    import madt_pkg::*;

    madt_evt_t q_evt;
    madt_evt_t head_evt;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_head_valid;

    // Parse bytes and push one event per byte that produces results
    madt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .table_bytes (table_bytes),
        .q_full      (q_full),
        .evt_push    (q_push),
        .evt         (q_evt)
    );

    // Hold pending events so the parse keeps going while the output stalls
    madt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_evt   (q_evt),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_evt   (head_evt)
    );

    // Expand each event into its record and summary words
    madt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_evt   (head_evt),
        .pop        (q_pop),
        .records    (records)
    );

`ifndef SYNTHESIS
    // The result stage only retires an event that is present
    a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("event popped from an empty queue");

    // A record that is not the last word of its byte is followed by the summary
    a_rec_then_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (records.valid && records.ready && !records.last) |=>
        (records.valid && records.kind == KIND_SUMMARY))
        else $error("summary did not follow a non-final record");

    // Bad length flag only ever rides on a summary word
    a_bad_on_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (records.valid && records.bad_length_stop) |->
        (records.kind == KIND_SUMMARY && records.last))
        else $error("bad length flag on a cpu record");
`endif

endmodule
